// File: sv/fscc_pkg.sv
// ----------------------------------------------------------------------------
// fscc_pkg: shared definitions for the free space cell classifier
// Holds the controller state type, the configuration register indexes, the
// port widths and the fixed luma weights.
// ----------------------------------------------------------------------------
package fscc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_GROUND_RGB  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_TOL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHROMA_BASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_TAPER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_FRAC   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_W      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_H      = 3'd6;

  // Q16 luma weights for red, green and blue; they sum to one.
  localparam logic [15:0] W_RED   = 16'd13933;
  localparam logic [15:0] W_GREEN = 16'd46871;
  localparam logic [15:0] W_BLUE  = 16'd4732;

  localparam logic [1:0] LSTEP_RED   = 2'd0;
  localparam logic [1:0] LSTEP_GREEN = 2'd1;
  localparam logic [1:0] LSTEP_BLUE  = 2'd2;
  localparam logic [1:0] LSTEP_DONE  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_THR,
    ST_SQR,
    ST_SQG,
    ST_TSQ,
    ST_CMP,
    ST_UPD,
    ST_ERD,
    ST_EMUL,
    ST_ECMP,
    ST_EOUT
  } state_t;

  // Luma weight used at a given step of the serial luma sum.
  function automatic logic [15:0] luma_w(input logic [1:0] step);
    logic [15:0] w;
    case (step)
      LSTEP_RED:   w = W_RED;
      LSTEP_GREEN: w = W_GREEN;
      LSTEP_BLUE:  w = W_BLUE;
      default:     w = 16'd0;
    endcase
    return w;
  endfunction

endpackage

// File: sv/fscc_in_if.sv
// ----------------------------------------------------------------------------
// fscc_in_if: pixel input channel
// Valid/ready channel carrying one tagged pixel per item.
// ----------------------------------------------------------------------------
interface fscc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       reached;
  logic [5:0] cell_col;
  logic [5:0] cell_row;
  logic       band_end;

  modport source (output valid, red, green, blue, reached, cell_col, cell_row, band_end,
                  input ready);
  modport sink   (input valid, red, green, blue, reached, cell_col, cell_row, band_end,
                  output ready);
endinterface

// File: sv/fscc_out_if.sv
// ----------------------------------------------------------------------------
// fscc_out_if: cell result channel
// Valid/ready channel carrying one cell verdict per item.
// ----------------------------------------------------------------------------
interface fscc_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] out_col;
  logic [5:0] out_row;
  logic       available;
  logic       row_last;

  modport source (output valid, out_col, out_row, available, row_last, input ready);
  modport sink   (input valid, out_col, out_row, available, row_last, output ready);
endinterface

// File: sv/fscc_div.sv
// ----------------------------------------------------------------------------
// fscc_div: bit-serial unsigned divider
// Restoring long division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fscc_div #(
  parameter int DW = 24,
  parameter int VW = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quot
);

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   num_r;
  logic [VW-1:0]   rem_r;
  logic [VW-1:0]   den_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic [VW:0]     trial;
  logic [VW:0]     diff;
  logic            ge;

  assign trial = {rem_r, num_r[DW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNTW'(DW - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // The dividend shifts out at the top while quotient bits shift in below.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      num_r <= {num_r[DW-2:0], ge};
      rem_r <= ge ? diff[VW-1:0] : trial[VW-1:0];
    end
  end

  assign busy = busy_r;
  assign quot = num_r;

endmodule

// File: sv/free_space_cell_classifier_unit.sv
// ----------------------------------------------------------------------------
// free_space_cell_classifier_unit: per-column free space vote over a band
// Classifies pixels as free ground and reports one availability bit per cell
// column at the end of each band.
// ----------------------------------------------------------------------------
// The block takes one pixel item at a time. The chromaticity ratios of the
// pixel and of the ground color and the row taper step are found by five
// bit-serial dividers running side by side, each finding one quotient bit
// at a time, while the serial luma sums are formed; the squared distances
// and the count update follow. A pixel is free if its reached flag is set,
// or if its luma lies within luma_tol of the ground luma and its squared
// chromaticity distance is within the square of the row-tapered threshold.
// Free and total counts per column live in a memory with one valid bit per
// column, so reset and band end clear them at once with no clearing pass.
// On a band_end pixel, after it is counted, the block sends one result item
// per column in use, each passing the read, multiply, compare and output
// states plus any wait on out_ch.ready; no pixel is taken until the last
// one is gone. Configuration may be written only while the block is idle.
// ----------------------------------------------------------------------------
module free_space_cell_classifier_unit #(
  parameter int MAX_COLS   = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  fscc_in_if.sink                        in_ch,
  fscc_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [fscc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [fscc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CB      = COUNT_BITS;
  localparam int COL_LIM = (MAX_COLS < 64) ? MAX_COLS : 64;

  // Configuration registers.
  logic [23:0] gnd_rgb_r;
  logic [7:0]  luma_tol_r;
  logic [15:0] chroma_base_r;
  logic [15:0] row_taper_r;
  logic [15:0] cell_frac_r;
  logic [6:0]  grid_w_r;
  logic [6:0]  grid_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gnd_rgb_r     <= 24'd8421504;
      luma_tol_r    <= 8'd12;
      chroma_base_r <= 16'd22938;
      row_taper_r   <= 16'd13107;
      cell_frac_r   <= 16'd36045;
      grid_w_r      <= 7'd40;
      grid_h_r      <= 7'd30;
    end else if (cfg_we) begin
      case (cfg_idx)
        fscc_pkg::REG_GROUND_RGB:  gnd_rgb_r     <= cfg_data;
        fscc_pkg::REG_LUMA_TOL:    luma_tol_r    <= cfg_data[7:0];
        fscc_pkg::REG_CHROMA_BASE: chroma_base_r <= cfg_data[15:0];
        fscc_pkg::REG_ROW_TAPER:   row_taper_r   <= cfg_data[15:0];
        fscc_pkg::REG_CELL_FRAC:   cell_frac_r   <= cfg_data[15:0];
        fscc_pkg::REG_GRID_W:      grid_w_r      <= cfg_data[6:0];
        fscc_pkg::REG_GRID_H:      grid_h_r      <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Columns in use, clamped to one through the column limit.
  logic [6:0] cols_w;
  always_comb begin
    if (grid_w_r == 7'd0) begin
      cols_w = 7'd1;
    end else if (grid_w_r > 7'(COL_LIM)) begin
      cols_w = 7'(COL_LIM);
    end else begin
      cols_w = grid_w_r;
    end
  end

  // Taper step: the row is clamped to the grid and divides by rows minus one.
  logic [6:0] h_eff;
  logic [6:0] denom;
  logic [6:0] gy;
  assign h_eff = (grid_h_r == 7'd0) ? 7'd1 : grid_h_r;
  assign denom = (h_eff > 7'd1) ? (h_eff - 7'd1) : 7'd1;

  fscc_pkg::state_t state_r, state_nxt;

  // Captured pixel item.
  logic [7:0] px_r_r, px_g_r, px_b_r;
  logic       reached_r;
  logic [5:0] col_r;
  logic [5:0] row_r;
  logic       band_r;

  assign gy = ({1'b0, row_r} > (h_eff - 7'd1)) ? (h_eff - 7'd1) : {1'b0, row_r};

  logic in_ready;
  logic div_start;
  logic in_acc;
  logic out_acc;

  assign in_acc  = in_ch.valid && in_ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r_r    <= in_ch.red;
      px_g_r    <= in_ch.green;
      px_b_r    <= in_ch.blue;
      reached_r <= in_ch.reached;
      col_r     <= in_ch.cell_col;
      row_r     <= in_ch.cell_row;
      band_r    <= in_ch.band_end;
    end
  end

  // Divisors: color sums, with zero taken as one.
  logic [9:0] sum_px, sum_gnd;
  logic [9:0] sum_px_raw, sum_gnd_raw;
  assign sum_px_raw  = 10'(px_r_r) + 10'(px_g_r) + 10'(px_b_r);
  assign sum_gnd_raw = 10'(gnd_rgb_r[23:16]) + 10'(gnd_rgb_r[15:8]) + 10'(gnd_rgb_r[7:0]);
  assign sum_px  = (sum_px_raw == 10'd0) ? 10'd1 : sum_px_raw;
  assign sum_gnd = (sum_gnd_raw == 10'd0) ? 10'd1 : sum_gnd_raw;

  logic [21:0] taper_num;
  assign taper_num = row_taper_r * gy[5:0];

  logic        busy_ar, busy_ag, busy_br, busy_bg, busy_tp;
  logic [23:0] q_ar, q_ag, q_br, q_bg;
  logic [21:0] q_tp;

  fscc_div #(.DW(24), .VW(10)) u_div_ar (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend({px_r_r, 16'd0}),
    .divisor(sum_px), .busy(busy_ar), .quot(q_ar));
  fscc_div #(.DW(24), .VW(10)) u_div_ag (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend({px_g_r, 16'd0}),
    .divisor(sum_px), .busy(busy_ag), .quot(q_ag));
  fscc_div #(.DW(24), .VW(10)) u_div_br (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend({gnd_rgb_r[23:16], 16'd0}),
    .divisor(sum_gnd), .busy(busy_br), .quot(q_br));
  fscc_div #(.DW(24), .VW(10)) u_div_bg (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend({gnd_rgb_r[15:8], 16'd0}),
    .divisor(sum_gnd), .busy(busy_bg), .quot(q_bg));
  fscc_div #(.DW(22), .VW(7)) u_div_tp (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(taper_num),
    .divisor(denom), .busy(busy_tp), .quot(q_tp));

  logic div_busy;
  assign div_busy = busy_ar || busy_ag || busy_br || busy_bg || busy_tp;

  // Serial luma: one channel per cycle for pixel and ground together.
  logic [1:0]  lstep_r;
  logic [23:0] y_acc_r, yg_acc_r;
  logic [7:0]  px_ch, gnd_ch;

  always_comb begin
    case (lstep_r)
      fscc_pkg::LSTEP_RED: begin
        px_ch  = px_r_r;
        gnd_ch = gnd_rgb_r[23:16];
      end
      fscc_pkg::LSTEP_GREEN: begin
        px_ch  = px_g_r;
        gnd_ch = gnd_rgb_r[15:8];
      end
      fscc_pkg::LSTEP_BLUE: begin
        px_ch  = px_b_r;
        gnd_ch = gnd_rgb_r[7:0];
      end
      default: begin
        px_ch  = 8'd0;
        gnd_ch = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == fscc_pkg::ST_LOAD) begin
      lstep_r  <= fscc_pkg::LSTEP_RED;
      y_acc_r  <= '0;
      yg_acc_r <= '0;
    end else if (state_r == fscc_pkg::ST_DIV && lstep_r != fscc_pkg::LSTEP_DONE) begin
      lstep_r  <= lstep_r + 2'd1;
      y_acc_r  <= y_acc_r + fscc_pkg::luma_w(lstep_r) * px_ch;
      yg_acc_r <= yg_acc_r + fscc_pkg::luma_w(lstep_r) * gnd_ch;
    end
  end

  // Threshold and squared distance, one multiplication per cycle.
  logic signed [17:0] dr_r, dg_r;
  logic [15:0]        thr_r;
  logic [32:0]        drsq_r, dgsq_r;
  logic [31:0]        tsq_r;
  logic [32:0]        thr_prod;
  logic [16:0]        thr_scale;
  logic signed [35:0] dr_sq, dg_sq;

  assign thr_scale = 17'h10000 - {1'b0, q_tp[15:0]};
  assign thr_prod  = chroma_base_r * thr_scale;
  assign dr_sq     = dr_r * dr_r;
  assign dg_sq     = dg_r * dg_r;

  always_ff @(posedge clk) begin
    case (state_r)
      fscc_pkg::ST_THR: begin
        thr_r <= thr_prod[31:16];
        dr_r  <= $signed({1'b0, q_ar[16:0]}) - $signed({1'b0, q_br[16:0]});
        dg_r  <= $signed({1'b0, q_ag[16:0]}) - $signed({1'b0, q_bg[16:0]});
      end
      fscc_pkg::ST_SQR: drsq_r <= dr_sq[32:0];
      fscc_pkg::ST_SQG: dgsq_r <= dg_sq[32:0];
      fscc_pkg::ST_TSQ: tsq_r  <= thr_r * thr_r;
      default: ;
    endcase
  end

  logic [7:0] y_px, y_gnd, dy;
  logic [33:0] dist2;
  logic        pix_free;
  assign y_px     = y_acc_r[23:16];
  assign y_gnd    = yg_acc_r[23:16];
  assign dy       = (y_px > y_gnd) ? (y_px - y_gnd) : (y_gnd - y_px);
  assign dist2    = {1'b0, drsq_r} + {1'b0, dgsq_r};
  assign pix_free = reached_r || ((dy <= luma_tol_r) && (dist2 <= {2'b00, tsq_r}));

  // Count memory: free count in the upper half, pixel count in the lower.
  logic [2*CB-1:0]     cnt_mem [MAX_COLS];
  logic [2*CB-1:0]     rd_r;
  logic [MAX_COLS-1:0] vld_r;
  logic                rd_vld_r;
  logic                free_r;
  logic                in_use_r;
  logic [6:0]          ecol_r;
  logic [CW-1:0]       rd_addr;
  logic                mem_re;
  logic                mem_we;
  logic [CB-1:0]       fr_cur, px_cur, fr_new, px_new;

  assign rd_addr = (state_r == fscc_pkg::ST_CMP) ? CW'(col_r) : CW'(ecol_r);
  assign fr_cur  = rd_vld_r ? rd_r[2*CB-1:CB] : '0;
  assign px_cur  = rd_vld_r ? rd_r[CB-1:0] : '0;
  assign px_new  = (px_cur == {CB{1'b1}}) ? px_cur : px_cur + 1'b1;
  assign fr_new  = (free_r && fr_cur != {CB{1'b1}}) ? fr_cur + 1'b1 : fr_cur;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[CW'(col_r)] <= {fr_new, px_new};
    end
    if (mem_re) begin
      rd_r     <= cnt_mem[rd_addr];
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == fscc_pkg::ST_CMP) begin
      free_r   <= pix_free;
      in_use_r <= {1'b0, col_r} < cols_w;
    end
  end

  // Emission: available when pixels is nonzero and free * 2^16 >= cell_frac * pixels.
  logic [CB+15:0] need_r;
  logic [CB+15:0] have;
  logic           last_col;
  logic           out_valid_r;
  logic [5:0]     out_col_r;
  logic           avail_r;
  logic           last_r;

  assign have     = {fr_cur, 16'd0};
  assign last_col = (ecol_r + 7'd1) == cols_w;

  always_ff @(posedge clk) begin
    if (state_r == fscc_pkg::ST_EMUL) begin
      need_r <= cell_frac_r * px_cur;
    end
    if (state_r == fscc_pkg::ST_ECMP) begin
      out_col_r <= ecol_r[5:0];
      avail_r   <= (px_cur != '0) && (have >= need_r);
      last_r    <= last_col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fscc_pkg::ST_IDLE;
      vld_r       <= '0;
      ecol_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mem_we) begin
        vld_r[CW'(col_r)] <= 1'b1;
      end
      if (state_r == fscc_pkg::ST_UPD) begin
        ecol_r <= '0;
      end
      if (state_r == fscc_pkg::ST_ECMP) begin
        out_valid_r <= 1'b1;
      end
      if (out_acc) begin
        out_valid_r <= 1'b0;
        ecol_r      <= ecol_r + 7'd1;
        if (last_r) begin
          vld_r <= '0;
        end
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fscc_pkg::ST_IDLE: if (in_ch.valid) state_nxt = fscc_pkg::ST_LOAD;
      fscc_pkg::ST_LOAD: state_nxt = fscc_pkg::ST_DIV;
      fscc_pkg::ST_DIV: begin
        if (!div_busy && lstep_r == fscc_pkg::LSTEP_DONE) state_nxt = fscc_pkg::ST_THR;
      end
      fscc_pkg::ST_THR:  state_nxt = fscc_pkg::ST_SQR;
      fscc_pkg::ST_SQR:  state_nxt = fscc_pkg::ST_SQG;
      fscc_pkg::ST_SQG:  state_nxt = fscc_pkg::ST_TSQ;
      fscc_pkg::ST_TSQ:  state_nxt = fscc_pkg::ST_CMP;
      fscc_pkg::ST_CMP:  state_nxt = fscc_pkg::ST_UPD;
      fscc_pkg::ST_UPD:  state_nxt = band_r ? fscc_pkg::ST_ERD : fscc_pkg::ST_IDLE;
      fscc_pkg::ST_ERD:  state_nxt = fscc_pkg::ST_EMUL;
      fscc_pkg::ST_EMUL: state_nxt = fscc_pkg::ST_ECMP;
      fscc_pkg::ST_ECMP: state_nxt = fscc_pkg::ST_EOUT;
      fscc_pkg::ST_EOUT: begin
        if (out_acc) state_nxt = last_r ? fscc_pkg::ST_IDLE : fscc_pkg::ST_ERD;
      end
      default: state_nxt = fscc_pkg::ST_IDLE;
    endcase
  end

  // Controls decoded from the state.
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    case (state_r)
      fscc_pkg::ST_IDLE: in_ready  = 1'b1;
      fscc_pkg::ST_LOAD: div_start = 1'b1;
      fscc_pkg::ST_CMP:  mem_re    = 1'b1;
      fscc_pkg::ST_UPD:  mem_we    = in_use_r;
      fscc_pkg::ST_ERD:  mem_re    = 1'b1;
      default: ;
    endcase
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_col   = out_col_r;
  assign out_ch.out_row   = row_r;
  assign out_ch.available = avail_r;
  assign out_ch.row_last  = last_r;

endmodule
